[rtl/wsmfb_pkg.sv]
// Shared types, constants and helpers for the masked WebSocket frame builder.
package wsmfb_pkg;

    typedef enum logic {
        MODE_START   = 1'b0,
        MODE_PAYLOAD = 1'b1
    } mode_t;

    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_MASK_KEY     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_OPCODE = 1'b1;

    localparam logic [31:0] MASK_KEY_RST     = 32'h37FA_213D;
    localparam logic [3:0]  FRAME_OPCODE_RST = 4'h1;

    localparam logic [7:0]  FIN_BIT     = 8'h80;
    localparam logic [7:0]  MASK_BIT    = 8'h80;
    localparam logic [15:0] LEN7_LIMIT  = 16'd126;
    localparam logic [6:0]  LEN16_CODE  = 7'd126;

    localparam int unsigned MAX_BYTES = 8;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                last_idx;
        logic                      frame_end;
        logic                      error;
    } item_t;

    function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = key[31:24];
            2'd1:    b = key[23:16];
            2'd2:    b = key[15:8];
            default: b = key[7:0];
        endcase
        return b;
    endfunction

endpackage

[rtl/wsmfb_if.sv]
// Valid/ready channel interfaces for input items and result bytes.
interface wsmfb_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] frame_length;
    logic [7:0]  payload_byte;

    modport source (output valid, output mode, output frame_length, output payload_byte,
                    input ready);
    modport sink   (input valid, input mode, input frame_length, input payload_byte,
                    output ready);
endinterface

interface wsmfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
    logic       error;

    modport source (output valid, output out_byte, output run_last, output frame_end,
                    output error, input ready);
    modport sink   (input valid, input out_byte, input run_last, input frame_end,
                    input error, output ready);
endinterface

[rtl/wsmfb_out_ser.sv]
// Result register and byte serializer: holds one item's bytes and emits them in order.
module wsmfb_out_ser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  wsmfb_pkg::item_t    item,
    output logic                can_load,
    wsmfb_out_if.source         result
);
    import wsmfb_pkg::*;

    logic       active_reg;
    logic [2:0] idx_reg;
    item_t      ent_reg;
    logic       at_last;

    assign at_last  = (idx_reg == ent_reg.last_idx);
    assign can_load = !active_reg || (result.ready && at_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else if (load)
        begin
            active_reg <= 1'b1;
            idx_reg    <= '0;
        end
        else if (active_reg && result.ready)
        begin
            if (at_last)
                active_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            ent_reg <= item;
    end

    assign result.valid     = active_reg;
    assign result.out_byte  = ent_reg.bytes[idx_reg];
    assign result.run_last  = at_last;
    assign result.frame_end = at_last && ent_reg.frame_end;
    assign result.error     = ent_reg.error;

endmodule

[rtl/websocket_masked_frame_builder.sv]
// The first result byte is valid in the cycle after the input transaction.
// A start item yields 6 header bytes (length below 126) or 8; a payload item yields 1.
// The next item is taken in the cycle the previous item's last byte is taken, so payload
// bytes stream at one per cycle while the output is ready, through one item register.
// Reset clears the open frame and restores mask key 0x37FA213D and opcode 1.
module websocket_masked_frame_builder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wsmfb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [wsmfb_pkg::CFG_DATA_W-1:0]    cfg_data,
    wsmfb_in_if.sink                            item,
    wsmfb_out_if.source                         result
);
    import wsmfb_pkg::*;

    logic [31:0] mask_key_reg;
    logic [3:0]  frame_opcode_reg;
    logic [15:0] bytes_left_reg;
    logic [15:0] bytes_left_next;
    logic [1:0]  key_index_reg;
    logic [1:0]  key_index_next;

    item_t       built;
    logic        can_load;
    logic        load;

    assign item.ready = can_load;
    assign load       = item.valid && can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_key_reg     <= MASK_KEY_RST;
            frame_opcode_reg <= FRAME_OPCODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MASK_KEY:     mask_key_reg     <= cfg_data;
                REG_FRAME_OPCODE: frame_opcode_reg <= cfg_data[3:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        built           = '0;
        bytes_left_next = bytes_left_reg;
        key_index_next  = key_index_reg;
        if (mode_t'(item.mode) == MODE_START)
        begin
            built.bytes[0]  = FIN_BIT | {4'h0, frame_opcode_reg};
            built.frame_end = (item.frame_length == 16'd0);
            if (item.frame_length < LEN7_LIMIT)
            begin
                built.bytes[1] = MASK_BIT | {1'b0, item.frame_length[6:0]};
                built.bytes[2] = key_byte(mask_key_reg, 2'd0);
                built.bytes[3] = key_byte(mask_key_reg, 2'd1);
                built.bytes[4] = key_byte(mask_key_reg, 2'd2);
                built.bytes[5] = key_byte(mask_key_reg, 2'd3);
                built.last_idx = 3'd5;
            end
            else
            begin
                built.bytes[1] = MASK_BIT | {1'b0, LEN16_CODE};
                built.bytes[2] = item.frame_length[15:8];
                built.bytes[3] = item.frame_length[7:0];
                built.bytes[4] = key_byte(mask_key_reg, 2'd0);
                built.bytes[5] = key_byte(mask_key_reg, 2'd1);
                built.bytes[6] = key_byte(mask_key_reg, 2'd2);
                built.bytes[7] = key_byte(mask_key_reg, 2'd3);
                built.last_idx = 3'd7;
            end
            bytes_left_next = item.frame_length;
            key_index_next  = 2'd0;
        end
        else if (bytes_left_reg == 16'd0)
        begin
            built.error = 1'b1;
        end
        else
        begin
            built.bytes[0]  = item.payload_byte ^ key_byte(mask_key_reg, key_index_reg);
            built.frame_end = (bytes_left_reg == 16'd1);
            bytes_left_next = bytes_left_reg - 16'd1;
            key_index_next  = key_index_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            key_index_reg  <= '0;
        end
        else if (load)
        begin
            bytes_left_reg <= bytes_left_next;
            key_index_reg  <= key_index_next;
        end
    end

    wsmfb_out_ser u_out_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .item     (built),
        .can_load (can_load),
        .result   (result)
    );

endmodule

[rtl/wsmfb_checker.sv]
// Port-level assertions for the masked WebSocket frame builder, bound to the top level.
module wsmfb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       frame_end,
    input logic       error
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped before transaction");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted item produced no result");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_end || error) |-> run_last)
        else $error("frame end or error on a non-final result");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> (out_byte == 8'h00) && !frame_end)
        else $error("error result carries data");

endmodule

bind websocket_masked_frame_builder wsmfb_checker u_wsmfb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_byte  (result.out_byte),
    .run_last  (result.run_last),
    .frame_end (result.frame_end),
    .error     (result.error)
);
